[sv/i2c_master_two_byte_read_core_defines.svh]
// Assertion macros for the I2C two-byte read master.
// Included by the top level; depends on nothing else.
`ifndef I2C_MASTER_TWO_BYTE_READ_CORE_DEFINES_SVH
`define I2C_MASTER_TWO_BYTE_READ_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a condition at every clock edge outside reset.
`define I2CM_CHECK_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that a condition implies another on the next clock edge.
`define I2CM_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define I2CM_CHECK_ALWAYS(lbl, clk, rst_n, cond, msg)
`define I2CM_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[sv/i2cm2r_pkg.sv]
// Shared types and constants for the I2C two-byte read master.
// No dependencies; imported by the top level.
package i2cm2r_pkg;

	localparam int TICK_COUNT_WIDTH_DEF = 16;
	localparam int CFG_DATA_W           = 16;

	localparam logic [15:0] HALF_PERIOD_RESET = 16'd10;
	localparam logic [6:0]  DEVICE_ADDR_RESET = 7'd80;

	// Configuration register indexes
	localparam logic REG_HALF_PERIOD = 1'b0;
	localparam logic REG_DEVICE_ADDR = 1'b1;

	typedef struct packed {
		logic start_request;
		logic sda_level;
		logic scl_level;
	} req_t;

	typedef struct packed {
		logic       sda_drive_low;
		logic       scl_drive_low;
		logic       busy_res;
		logic       done_res;
		logic       no_ack;
		logic [7:0] read_data;
	} rsp_t;

endpackage

[sv/i2c_master_two_byte_read_core.sv]
// I2C master that performs an address write, a repeated START and a two-byte read.
// Depends on i2cm2r_pkg and i2c_master_two_byte_read_core_defines.svh.
//
// Usage:
// - Request channel (req_valid / req_stall / req): each beat is one sampled tick of
//   the bus, carrying start_request and the sampled SDA and SCL levels.
// - Response channel (rsp_valid / rsp_stall / rsp): exactly one beat per request beat,
//   carrying the line drives, busy, a one-tick done pulse, no_ack and the first byte.
// - Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 sets the
//   half period in ticks, index 1 the seven-bit device address. Write only while idle.
// Response: registered; it appears in the cycle after its request beat is taken.
// Throughput: one request beat per cycle unless stalled; the sequencer step is a
// single pass of decode logic between the state registers and the response register.
// Reset: the sequencer goes idle with all counters and flags clear, the response
// register empties, and the config registers return to 10 ticks and address 80.
// Stall: while a response waits under rsp_stall, req_stall is raised and the state
// holds; a response that drains in the same cycle frees room for the next beat.
// Bus timing: every phase lasts half_period ticks; phases that release SCL wait for
// SCL to read high before counting (clock stretching), and sample there.

`include "i2c_master_two_byte_read_core_defines.svh"

module i2c_master_two_byte_read_core
	import i2cm2r_pkg::*;
#(
	parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int TW = TICK_COUNT_WIDTH;
	localparam int LW = (TW > 16) ? TW : 16;

	// Sequencer phase codes
	localparam logic [4:0] PH_IDLE       = 5'd0;
	localparam logic [4:0] PH_ST_REL     = 5'd1;
	localparam logic [4:0] PH_ST_SDA     = 5'd2;
	localparam logic [4:0] PH_ST_SCL     = 5'd3;
	localparam logic [4:0] PH_WR_LOW     = 5'd4;
	localparam logic [4:0] PH_WR_HIGH    = 5'd5;
	localparam logic [4:0] PH_WA_LOW     = 5'd6;
	localparam logic [4:0] PH_WA_HIGH    = 5'd7;
	localparam logic [4:0] PH_WA_END     = 5'd8;
	localparam logic [4:0] PH_RD1_LOW    = 5'd9;
	localparam logic [4:0] PH_RD1_HIGH   = 5'd10;
	localparam logic [4:0] PH_MACK_LOW   = 5'd11;
	localparam logic [4:0] PH_MACK_HIGH  = 5'd12;
	localparam logic [4:0] PH_RD2_LOW    = 5'd13;
	localparam logic [4:0] PH_RD2_HIGH   = 5'd14;
	localparam logic [4:0] PH_MNACK_LOW  = 5'd15;
	localparam logic [4:0] PH_MNACK_HIGH = 5'd16;
	localparam logic [4:0] PH_SP_LOW     = 5'd17;
	localparam logic [4:0] PH_SP_SCL     = 5'd18;
	localparam logic [4:0] PH_SP_SDA     = 5'd19;

	// Config registers
	logic [15:0] half_period_q;
	logic [6:0]  dev_addr_q;

	// Sequencer state
	logic [4:0]    ph_q, ph_d;
	logic [2:0]    bit_q, bit_d;
	logic [7:0]    sh_q, sh_d;
	logic [TW-1:0] tc_q, tc_d;
	logic [7:0]    first_q, first_d;
	logic          nack_q, nack_d;

	// Response register
	logic rsp_valid_q;
	rsp_t rsp_q, rsp_d;

	logic accept;
	logic done_d;

	// Phase timer
	logic [LW-1:0] hp_ext, mask_ext;
	logic [TW-1:0] limit, tc_inc, tc_hold;
	logic          stretch, stretch_wait, first, fin;
	logic [7:0]    sh_rd;

	assign cfg_ready = 1'b1;

	// Take a new beat whenever the response register is empty or drains now.
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
			dev_addr_q    <= DEVICE_ADDR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HALF_PERIOD: half_period_q <= cfg_data[15:0];
				REG_DEVICE_ADDR: dev_addr_q    <= cfg_data[6:0];
				default:         half_period_q <= half_period_q;
			endcase
		end
	end

	// Phase length: a zero half period acts as one, and clip to the counter range.
	always_comb begin
		hp_ext   = LW'(half_period_q);
		mask_ext = LW'({TW{1'b1}});
		if (half_period_q == 16'd0)
			limit = TW'(1);
		else if (hp_ext > mask_ext)
			limit = {TW{1'b1}};
		else
			limit = hp_ext[TW-1:0];
	end

	// Phases that release SCL wait for it to read high before counting.
	always_comb begin
		case (ph_q)
			PH_ST_REL, PH_WR_HIGH, PH_WA_HIGH, PH_RD1_HIGH, PH_RD2_HIGH,
			PH_MACK_HIGH, PH_MNACK_HIGH, PH_SP_SCL: stretch = 1'b1;
			default:                                stretch = 1'b0;
		endcase
		stretch_wait = stretch && (tc_q == '0) && !req.scl_level;
		first        = !stretch_wait && (tc_q == '0);
		tc_inc       = tc_q + TW'(1);
		fin          = !stretch_wait && (tc_inc >= limit);
		if (stretch_wait)
			tc_hold = tc_q;
		else if (fin)
			tc_hold = '0;
		else
			tc_hold = tc_inc;
		sh_rd = first ? {sh_q[6:0], req.sda_level} : sh_q;
	end

	// Sequencer step
	always_comb begin
		ph_d    = ph_q;
		bit_d   = bit_q;
		sh_d    = sh_q;
		tc_d    = tc_hold;
		first_d = first_q;
		nack_d  = nack_q;
		done_d  = 1'b0;
		case (ph_q)
			PH_IDLE: begin
				tc_d = tc_q;
				if (req.start_request) begin
					sh_d    = {dev_addr_q, 1'b0};
					bit_d   = 3'd0;
					tc_d    = '0;
					first_d = 8'd0;
					nack_d  = 1'b0;
					ph_d    = PH_ST_REL;
				end
			end
			PH_ST_REL: if (fin) ph_d = PH_ST_SDA;
			PH_ST_SDA: if (fin) ph_d = PH_ST_SCL;
			PH_ST_SCL: begin
				if (fin) begin
					bit_d = 3'd0;
					ph_d  = PH_WR_LOW;
				end
			end
			PH_WR_LOW: if (fin) ph_d = PH_WR_HIGH;
			PH_WR_HIGH: begin
				if (fin) begin
					if (bit_q == 3'd7) begin
						bit_d = 3'd0;
						ph_d  = PH_WA_LOW;
					end else begin
						bit_d = bit_q + 3'd1;
						ph_d  = PH_WR_LOW;
					end
				end
			end
			PH_WA_LOW: if (fin) ph_d = PH_WA_HIGH;
			PH_WA_HIGH: begin
				if (fin) ph_d = PH_WA_END;
				if (first) nack_d = req.sda_level;
			end
			PH_WA_END: begin
				if (fin) begin
					if (nack_q) begin
						ph_d = PH_SP_LOW;
					end else if (!sh_q[0]) begin
						// Address went out with the write bit; go back for the read.
						sh_d = {dev_addr_q, 1'b1};
						ph_d = PH_ST_REL;
					end else begin
						sh_d  = 8'd0;
						bit_d = 3'd0;
						ph_d  = PH_RD1_LOW;
					end
				end
			end
			PH_RD1_LOW, PH_RD2_LOW, PH_MACK_LOW, PH_MNACK_LOW: begin
				if (fin) ph_d = ph_q + 5'd1;
			end
			PH_RD1_HIGH, PH_RD2_HIGH: begin
				sh_d = sh_rd;
				if (fin) begin
					if (bit_q == 3'd7) begin
						bit_d = 3'd0;
						sh_d  = 8'd0;
						if (ph_q == PH_RD1_HIGH) begin
							first_d = sh_rd;
							ph_d    = PH_MACK_LOW;
						end else begin
							ph_d = PH_MNACK_LOW;
						end
					end else begin
						bit_d = bit_q + 3'd1;
						ph_d  = ph_q - 5'd1;
					end
				end
			end
			PH_MACK_HIGH:  if (fin) ph_d = PH_RD2_LOW;
			PH_MNACK_HIGH: if (fin) ph_d = PH_SP_LOW;
			PH_SP_LOW:     if (fin) ph_d = PH_SP_SCL;
			PH_SP_SCL:     if (fin) ph_d = PH_SP_SDA;
			PH_SP_SDA: begin
				if (fin) begin
					ph_d   = PH_IDLE;
					done_d = 1'b1;
				end
			end
			default: begin
				// Drop an unused code back to idle without a done pulse.
				ph_d  = PH_IDLE;
				tc_d  = '0;
				bit_d = 3'd0;
			end
		endcase
	end

	// Line drives follow the phase entered on this tick.
	always_comb begin
		rsp_d = '0;
		case (ph_d)
			PH_ST_SDA, PH_MACK_HIGH, PH_SP_SCL: begin
				rsp_d.sda_drive_low = 1'b1;
			end
			PH_ST_SCL, PH_MACK_LOW, PH_SP_LOW: begin
				rsp_d.sda_drive_low = 1'b1;
				rsp_d.scl_drive_low = 1'b1;
			end
			PH_WR_LOW: begin
				rsp_d.sda_drive_low = !sh_d[~bit_d];
				rsp_d.scl_drive_low = 1'b1;
			end
			PH_WR_HIGH: begin
				rsp_d.sda_drive_low = !sh_d[~bit_d];
			end
			PH_WA_LOW, PH_WA_END, PH_RD1_LOW, PH_RD2_LOW, PH_MNACK_LOW: begin
				rsp_d.scl_drive_low = 1'b1;
			end
			default: rsp_d.sda_drive_low = 1'b0;
		endcase
		rsp_d.busy_res  = (ph_d != PH_IDLE);
		rsp_d.done_res  = done_d;
		rsp_d.no_ack    = nack_d;
		rsp_d.read_data = first_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_IDLE;
			bit_q   <= 3'd0;
			sh_q    <= 8'd0;
			tc_q    <= '0;
			first_q <= 8'd0;
			nack_q  <= 1'b0;
		end else if (accept) begin
			ph_q    <= ph_d;
			bit_q   <= bit_d;
			sh_q    <= sh_d;
			tc_q    <= tc_d;
			first_q <= first_d;
			nack_q  <= nack_d;
		end
	end

	// Hold the response until taken; refill on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) rsp_q <= rsp_d;
	end

	`I2CM_CHECK_ALWAYS(a_phase_range, clk, arst_n, ph_q <= PH_SP_SDA, "phase code out of range")
	`I2CM_CHECK_ALWAYS(a_done_idle, clk, arst_n, !(rsp_valid_q && rsp_q.done_res && rsp_q.busy_res), "done while busy")
	`I2CM_CHECK_NEXT(a_idle_quiet, clk, arst_n, accept && ph_q == PH_IDLE && !req.start_request, !rsp_q.busy_res && !rsp_q.scl_drive_low && !rsp_q.sda_drive_low, "idle tick drove the bus")
	`I2CM_CHECK_NEXT(a_accept_fills, clk, arst_n, accept, rsp_valid_q, "accepted beat gave no response")

endmodule

[tb/i2c_read_checker.sv]
`timescale 1ns / 100ps
// Checker for the I2C two-byte read master: watches the request, response and config
// channels, predicts each response tick and compares it. Depends on i2cm2r_pkg.
module i2c_read_checker
	import i2cm2r_pkg::*;
#(
	parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic                  req_stall,
	input  req_t                  req,
	input  logic                  rsp_valid,
	input  logic                  rsp_stall,
	input  rsp_t                  rsp,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatch_count,
	output int                    ticks_owed,
	output logic                  seq_busy,
	output logic                  line_scl_low,
	output logic                  line_sda_low,
	output logic                  ack_slot
);

	typedef enum logic [4:0] {
		P_IDLE, P_START_REL, P_START_SDA, P_START_SCL, P_WR_LOW, P_WR_HIGH,
		P_WACK_LOW, P_WACK_HIGH, P_WACK_END, P_RD1_LOW, P_RD1_HIGH,
		P_MACK_LOW, P_MACK_HIGH, P_RD2_LOW, P_RD2_HIGH, P_MNACK_LOW,
		P_MNACK_HIGH, P_STOP_LOW, P_STOP_SCL, P_STOP_SDA
	} bus_phase_t;

	bus_phase_t                  phase;
	logic [2:0]                  bit_idx;
	logic [7:0]                  shreg;
	logic [TICK_COUNT_WIDTH-1:0] tick_cnt;
	logic [7:0]                  first_byte;
	logic                        nack;
	logic [15:0]                 half_period;
	logic [6:0]                  addr_reg;
	rsp_t                        predicted_ticks[$];
	int                          errs;

	// Count one tick of the current phase; report when it has run its full length.
	function automatic bit phase_done(input bit stretch, input logic scl, output bit first_tick);
		longint unsigned limit;
		longint unsigned cnt_max;
		cnt_max = (longint'(1) << TICK_COUNT_WIDTH) - 1;
		limit = half_period;
		if (limit == 0) limit = 1;
		if (limit > cnt_max) limit = cnt_max;
		first_tick = 1'b0;
		// hold the count while the target stretches the clock
		if (stretch && tick_cnt == '0 && !scl) return 1'b0;
		if (tick_cnt == '0) first_tick = 1'b1;
		tick_cnt = tick_cnt + 1'b1;
		if (tick_cnt >= limit) begin
			tick_cnt = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic rsp_t step_sequencer(input req_t r);
		rsp_t o;
		bit   ft;
		bit   fin;
		logic wb;
		logic done;
		done = 1'b0;
		case (phase)
			P_IDLE: if (r.start_request) begin
				shreg = {addr_reg, 1'b0};
				bit_idx = '0;
				tick_cnt = '0;
				first_byte = '0;
				nack = 1'b0;
				phase = P_START_REL;
			end
			P_START_REL: if (phase_done(1'b1, r.scl_level, ft)) phase = P_START_SDA;
			P_START_SDA: if (phase_done(1'b0, r.scl_level, ft)) phase = P_START_SCL;
			P_START_SCL: if (phase_done(1'b0, r.scl_level, ft)) begin
				bit_idx = '0;
				phase = P_WR_LOW;
			end
			P_WR_LOW: if (phase_done(1'b0, r.scl_level, ft)) phase = P_WR_HIGH;
			P_WR_HIGH: if (phase_done(1'b1, r.scl_level, ft)) begin
				if (bit_idx == 3'd7) begin
					bit_idx = '0;
					phase = P_WACK_LOW;
				end else begin
					bit_idx = bit_idx + 1'b1;
					phase = P_WR_LOW;
				end
			end
			P_WACK_LOW: if (phase_done(1'b0, r.scl_level, ft)) phase = P_WACK_HIGH;
			P_WACK_HIGH: begin
				fin = phase_done(1'b1, r.scl_level, ft);
				if (fin) phase = P_WACK_END;
				if (ft) nack = r.sda_level;
			end
			P_WACK_END: if (phase_done(1'b0, r.scl_level, ft)) begin
				if (nack) phase = P_STOP_LOW;
				else if (!shreg[0]) begin
					// address went out with the write bit: resend it for reading
					shreg = {addr_reg, 1'b1};
					phase = P_START_REL;
				end else begin
					shreg = '0;
					bit_idx = '0;
					phase = P_RD1_LOW;
				end
			end
			P_RD1_LOW: if (phase_done(1'b0, r.scl_level, ft)) phase = P_RD1_HIGH;
			P_RD2_LOW: if (phase_done(1'b0, r.scl_level, ft)) phase = P_RD2_HIGH;
			P_RD1_HIGH, P_RD2_HIGH: begin
				fin = phase_done(1'b1, r.scl_level, ft);
				if (ft) shreg = {shreg[6:0], r.sda_level};
				if (fin) begin
					if (bit_idx == 3'd7) begin
						bit_idx = '0;
						if (phase == P_RD1_HIGH) begin
							first_byte = shreg;
							phase = P_MACK_LOW;
						end else begin
							phase = P_MNACK_LOW;
						end
						shreg = '0;
					end else begin
						bit_idx = bit_idx + 1'b1;
						phase = (phase == P_RD1_HIGH) ? P_RD1_LOW : P_RD2_LOW;
					end
				end
			end
			P_MACK_LOW: if (phase_done(1'b0, r.scl_level, ft)) phase = P_MACK_HIGH;
			P_MNACK_LOW: if (phase_done(1'b0, r.scl_level, ft)) phase = P_MNACK_HIGH;
			P_MACK_HIGH: if (phase_done(1'b1, r.scl_level, ft)) phase = P_RD2_LOW;
			P_MNACK_HIGH: if (phase_done(1'b1, r.scl_level, ft)) phase = P_STOP_LOW;
			P_STOP_LOW: if (phase_done(1'b0, r.scl_level, ft)) phase = P_STOP_SCL;
			P_STOP_SCL: if (phase_done(1'b1, r.scl_level, ft)) phase = P_STOP_SDA;
			P_STOP_SDA: if (phase_done(1'b0, r.scl_level, ft)) begin
				phase = P_IDLE;
				done = 1'b1;
			end
			default: begin
				phase = P_IDLE;
				tick_cnt = '0;
				bit_idx = '0;
			end
		endcase

		wb = shreg[3'd7 - bit_idx];
		case (phase)
			P_START_SDA: begin o.sda_drive_low = 1'b1; o.scl_drive_low = 1'b0; end
			P_START_SCL: begin o.sda_drive_low = 1'b1; o.scl_drive_low = 1'b1; end
			P_WR_LOW:    begin o.sda_drive_low = ~wb;  o.scl_drive_low = 1'b1; end
			P_WR_HIGH:   begin o.sda_drive_low = ~wb;  o.scl_drive_low = 1'b0; end
			P_WACK_LOW, P_WACK_END, P_RD1_LOW, P_RD2_LOW, P_MNACK_LOW: begin
				o.sda_drive_low = 1'b0;
				o.scl_drive_low = 1'b1;
			end
			P_MACK_LOW, P_STOP_LOW: begin o.sda_drive_low = 1'b1; o.scl_drive_low = 1'b1; end
			P_MACK_HIGH, P_STOP_SCL: begin o.sda_drive_low = 1'b1; o.scl_drive_low = 1'b0; end
			default:     begin o.sda_drive_low = 1'b0; o.scl_drive_low = 1'b0; end
		endcase
		o.busy_res  = (phase != P_IDLE);
		o.done_res  = done;
		o.no_ack    = nack;
		o.read_data = first_byte;
		return o;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			errs++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		rsp_t pred;
		if (!arst_n) begin
			phase = P_IDLE;
			bit_idx = '0;
			shreg = '0;
			tick_cnt = '0;
			first_byte = '0;
			nack = 1'b0;
			half_period = HALF_PERIOD_RESET;
			addr_reg = DEVICE_ADDR_RESET;
			predicted_ticks.delete();
			errs = 0;
			mismatch_count <= 0;
			ticks_owed <= 0;
			seq_busy <= 1'b0;
			line_scl_low <= 1'b0;
			line_sda_low <= 1'b0;
			ack_slot <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_HALF_PERIOD) half_period = cfg_data;
				else addr_reg = cfg_data[6:0];
			end
			if (rsp_valid && !rsp_stall) begin
				if (predicted_ticks.size() == 0) begin
					errs++;
					$display("%0t: response beat with nothing expected, expected none actual %0h",
						$time, rsp);
				end else begin
					want = predicted_ticks.pop_front();
					check_field("sda_drive_low", 8'(want.sda_drive_low),
						8'(rsp.sda_drive_low));
					check_field("scl_drive_low", 8'(want.scl_drive_low),
						8'(rsp.scl_drive_low));
					check_field("busy_res", 8'(want.busy_res), 8'(rsp.busy_res));
					check_field("done_res", 8'(want.done_res), 8'(rsp.done_res));
					check_field("no_ack", 8'(want.no_ack), 8'(rsp.no_ack));
					check_field("read_data", want.read_data, rsp.read_data);
				end
			end
			if (req_valid && !req_stall) begin
				pred = step_sequencer(req);
				predicted_ticks.push_back(pred);
				seq_busy <= pred.busy_res;
				line_scl_low <= pred.scl_drive_low;
				line_sda_low <= pred.sda_drive_low;
				ack_slot <= (phase inside {P_WACK_LOW, P_WACK_HIGH, P_WACK_END});
			end
			mismatch_count <= errs;
			ticks_owed <= predicted_ticks.size();
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Top of the I2C two-byte read master testbench: clock, reset, bus-following stimulus,
// random response stalls and the verdict. Needs i2cm2r_pkg, the checker and the core.
module tb_top;
	import i2cm2r_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_stall;
	rsp_t                  rsp;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic                  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int   mismatch_count;
	int   ticks_owed;
	logic seq_busy;
	logic line_scl_low;
	logic line_sda_low;
	logic ack_slot;

	// no-idle stretches for both sides when set
	bit calm;
	// ticks left in a clock stretch from the simulated target
	int stretch_left;
	// target refuses every address byte when set
	bit nack_all;

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	i2c_master_two_byte_read_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	i2c_read_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req            (req),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.rsp            (rsp),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.ticks_owed     (ticks_owed),
		.seq_busy       (seq_busy),
		.line_scl_low   (line_scl_low),
		.line_sda_low   (line_sda_low),
		.ack_slot       (ack_slot)
	);

	// Present one request beat after a random gap. With follow_bus set, build the line
	// levels from the master's current drives as a well-behaved target would: SCL reads
	// high when released (apart from short stretches), ACK is mostly given, read data is
	// random, and SDA reads low whenever the master pulls it. The start bit comes from
	// base. Valid stays high after the beat so a back-to-back beat never toggles it.
	task automatic send_beat(input req_t base, input bit follow_bus);
		int   gap;
		req_t r;
		logic target_sda;
		gap = calm ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		r = base;
		if (follow_bus) begin
			if (line_scl_low) begin
				r.scl_level = 1'b0;
			end else if (stretch_left > 0) begin
				r.scl_level = 1'b0;
				stretch_left--;
			end else begin
				r.scl_level = 1'b1;
				if ($urandom_range(0, 24) == 0) stretch_left = $urandom_range(1, 8);
			end
			// ack slot: drive ACK most of the time, else leave the line floating high
			target_sda = ack_slot ? (nack_all || ($urandom_range(0, 15) == 0)) :
				1'($urandom_range(0, 1));
			r.sda_level = target_sda & ~line_sda_low;
		end
		req <= r;
		req_valid <= 1'b1;
		// advance only on a taken beat
		do @(posedge clk); while (req_stall);
	endtask

	// Drop valid and hold until every predicted response beat has been taken.
	task automatic wait_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (ticks_owed != 0);
	endtask

	// Run the bus until the sequencer is back in idle, then drain the responses.
	task automatic finish_transfer();
		req_t r;
		wait_results();
		r = '0;
		while (seq_busy) send_beat(r, 1'b1);
		wait_results();
	endtask

	// Write both registers back to back; valid stays high across the two beats.
	task automatic set_config(input logic [15:0] hp, input logic [6:0] addr);
		cfg_valid <= 1'b1;
		cfg_index <= REG_HALF_PERIOD;
		cfg_data <= hp;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_DEVICE_ADDR;
		cfg_data <= {{(CFG_DATA_W - 7){1'b0}}, addr};
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// One random stretch at a given setting: mostly bus-following beats with frequent
	// start requests (ignored while busy), some pure noise beats.
	task automatic run_segment(input logic [15:0] hp, input logic [6:0] addr, input int n,
		input bit settle);
		req_t r;
		if (settle) finish_transfer();
		set_config(hp, addr);
		for (int k = 0; k < n; k++) begin
			if (k % 40 == 0) calm <= ($urandom_range(0, 3) == 0);
			// pause the sender until every result is back, mid-transfer
			if (k == n / 2) wait_results();
			if ($urandom_range(0, 6) == 0) begin
				r.start_request = 1'($urandom_range(0, 1));
				r.sda_level = 1'($urandom_range(0, 1));
				r.scl_level = 1'($urandom_range(0, 1));
				send_beat(r, 1'b0);
			end else begin
				r = '0;
				r.start_request = ($urandom_range(0, 3) == 0);
				send_beat(r, 1'b1);
			end
		end
	endtask

	// Response side: draw a stall length per beat, then take the beat.
	initial begin : rsp_sink
		int hold_n;
		rsp_stall <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			hold_n = calm ? 0 : $urandom_range(0, 17);
			if (hold_n > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold_n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	initial begin : stimulus
		req_t r;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_HALF_PERIOD;
		cfg_data <= '0;
		calm <= 1'b0;
		stretch_left = 0;
		nack_all = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset settings (10 ticks, address 80).
		// Idle with every line combination and no start: nothing moves.
		for (int i = 0; i < 4; i++) begin
			r.start_request = 1'b0;
			r.sda_level = i[1];
			r.scl_level = i[0];
			send_beat(r, 1'b0);
		end
		// Start with SCL held low by the target: the release phase must not count.
		r = '{start_request: 1'b1, sda_level: 1'b1, scl_level: 1'b0};
		send_beat(r, 1'b0);
		r.start_request = 1'b0;
		repeat (3) send_beat(r, 1'b0);
		// Start request while busy: ignored.
		r.start_request = 1'b1;
		send_beat(r, 1'b0);
		// Let the clock go and keep asking to start while the transfer runs.
		repeat (15) send_beat(r, 1'b1);
		// Refuse the write address: the master stops early and flags no_ack.
		nack_all = 1'b1;
		finish_transfer();
		nack_all = 1'b0;

		// Random part over several settings; half period zero acts as one.
		run_segment(16'd0, 7'd0, 120, 1'b1);
		run_segment(16'd1, 7'd127, 120, 1'b1);
		run_segment(16'd2, 7'($urandom_range(0, 127)), 120, 1'b1);
		run_segment(16'd3, 7'($urandom_range(0, 127)), 120, 1'b1);
		run_segment(16'($urandom_range(1, 6)), 7'($urandom_range(0, 127)), 120, 1'b1);
		// Largest half period last: a transfer this slow never completes here, so no
		// later register write has to wait for it.
		run_segment(16'hFFFF, 7'($urandom_range(0, 127)), 90, 1'b1);

		wait_results();
		// allow for the registered response and a little slack
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && ticks_owed == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin : watchdog
		#8_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/i2cm2r_pkg.sv
sv/i2c_master_two_byte_read_core.sv
tb/i2c_read_checker.sv
tb/tb_top.sv
